// File: rtl/keyed_record_table_compacting_core_assert.svh
// Assertion macros used by the record table top level.
`ifndef KEYED_RECORD_TABLE_COMPACTING_CORE_ASSERT_SVH
`define KEYED_RECORD_TABLE_COMPACTING_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("record table assertion failed");

// Next-cycle implication, disabled during reset.
`define KCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("record table assertion failed");

`endif

// File: rtl/kct_pkg.sv
// Types and constants of the keyed record table.
package kct_pkg;

  localparam int KCT_DEPTH = 128;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_LOOKUP,
    KIND_UPDATE,
    KIND_DELETE
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_FULL,
    ST_DUP,
    ST_MISSING,
    ST_EMPTY
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_t;

  // One stored record
  typedef struct packed {
    logic signed [31:0] key;
    logic [23:0]        duration;
    logic [31:0]        record_ref;
  } rec_t;

  // One request as taken from the input channel
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] key;
    logic [23:0]        duration;
    logic [31:0]        record_ref;
  } item_t;

  // One result as handed to the output register
  typedef struct packed {
    status_t            status;
    logic [6:0]         found_index;
    logic signed [31:0] found_key;
    logic [23:0]        found_duration;
    logic [31:0]        found_ref;
    logic [7:0]         entry_count;
  } res_t;

endpackage

// File: rtl/kct_if.sv
// Valid/ready channel interfaces for requests and results.
interface kct_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] key;
  logic [23:0]        duration;
  logic [31:0]        record_ref;

  modport source (output valid, kind, key, duration, record_ref, input ready);
  modport sink (input valid, kind, key, duration, record_ref, output ready);
endinterface

interface kct_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [6:0]         found_index;
  logic signed [31:0] found_key;
  logic [23:0]        found_duration;
  logic [31:0]        found_ref;
  logic [7:0]         entry_count;

  modport source (output valid, status, found_index, found_key, found_duration,
                  found_ref, entry_count, input ready);
  modport sink (input valid, status, found_index, found_key, found_duration,
                found_ref, entry_count, output ready);
endinterface

// File: rtl/kct_mem.sv
// Record memory: one write port, one registered read port.
module kct_mem
  import kct_pkg::*;
#(
  parameter int DEPTH = KCT_DEPTH,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  rec_t          wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output rec_t          rdata
);

  rec_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/kct_ctrl.sv
// Sequencer: linear search, insert, update and compacting delete over the memory.
module kct_ctrl
  import kct_pkg::*;
#(
  parameter int DEPTH = KCT_DEPTH,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  item_t         in_item,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  output logic          mem_we,
  output logic [IW-1:0] mem_waddr,
  output rec_t          mem_wdata,
  output logic          mem_re,
  output logic [IW-1:0] mem_raddr,
  input  rec_t          mem_rdata
);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          dval_r, dval_nxt;
  logic [IW-1:0] didx_r, didx_nxt;
  item_t         item_r, item_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  rec_t          rec_r, rec_nxt;
  status_t       status_r, status_nxt;
  logic          hit_r, hit_nxt;

  logic issuing;
  logic match;
  rec_t new_rec;

  assign issuing   = (iss_r < count_r);
  assign match     = dval_r && (mem_rdata.key == item_r.key);
  assign new_rec   = '{key: item_r.key, duration: item_r.duration,
                       record_ref: item_r.record_ref};
  assign mem_raddr = iss_r[IW-1:0];
  assign in_ready  = (state_r == S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      dval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      dval_r  <= dval_nxt;
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk) begin
    iss_r    <= iss_nxt;
    didx_r   <= didx_nxt;
    item_r   <= item_nxt;
    pos_r    <= pos_nxt;
    rec_r    <= rec_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
  end

  // Next state, memory accesses and result
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    iss_nxt    = iss_r;
    dval_nxt   = 1'b0;
    didx_nxt   = didx_r;
    item_nxt   = item_r;
    pos_nxt    = pos_r;
    rec_nxt    = rec_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    mem_we     = 1'b0;
    mem_waddr  = didx_r;
    mem_wdata  = new_rec;
    mem_re     = 1'b0;
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item;
          iss_nxt  = '0;
          hit_nxt  = 1'b0;
          // Full is checked before any search
          if (in_item.kind == KIND_INSERT && count_r == CW'(DEPTH)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else if (in_item.kind != KIND_INSERT && count_r == '0) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (match) begin
          pos_nxt    = didx_r;
          hit_nxt    = 1'b1;
          status_nxt = ST_OK;
          rec_nxt    = mem_rdata;
          case (item_r.kind)
            KIND_INSERT: begin
              status_nxt = ST_DUP;
              state_nxt  = S_RESP;
            end
            KIND_LOOKUP: begin
              state_nxt = S_RESP;
            end
            KIND_UPDATE: begin
              // Rewrite in place; the key is the one just matched
              mem_we    = 1'b1;
              mem_waddr = didx_r;
              mem_wdata = new_rec;
              rec_nxt   = new_rec;
              state_nxt = S_RESP;
            end
            KIND_DELETE: begin
              // Start compaction at the entry after the removed one
              iss_nxt   = CW'(didx_r) + CW'(1);
              state_nxt = S_SHIFT;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end else if (!dval_r && !issuing) begin
          // Every entry compared without a hit
          if (item_r.kind == KIND_INSERT) begin
            mem_we     = 1'b1;
            mem_waddr  = count_r[IW-1:0];
            mem_wdata  = new_rec;
            rec_nxt    = new_rec;
            pos_nxt    = count_r[IW-1:0];
            hit_nxt    = 1'b1;
            status_nxt = ST_OK;
            count_nxt  = count_r + CW'(1);
          end else begin
            status_nxt = ST_MISSING;
          end
          state_nxt = S_RESP;
        end else if (issuing) begin
          // Read the next entry while the previous one is compared
          mem_re   = 1'b1;
          iss_nxt  = iss_r + CW'(1);
          dval_nxt = 1'b1;
          didx_nxt = iss_r[IW-1:0];
        end
      end

      S_SHIFT: begin
        // Move each later entry down one place; reads run ahead of writes
        if (dval_r) begin
          mem_we    = 1'b1;
          mem_waddr = IW'(didx_r - 1'b1);
          mem_wdata = mem_rdata;
        end
        if (issuing) begin
          mem_re   = 1'b1;
          iss_nxt  = iss_r + CW'(1);
          dval_nxt = 1'b1;
          didx_nxt = iss_r[IW-1:0];
        end else if (!dval_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result fields; records not found read as zero
  always_comb begin
    res.status         = status_r;
    res.found_index    = hit_r ? 7'(pos_r) : '0;
    res.found_key      = hit_r ? rec_r.key : '0;
    res.found_duration = hit_r ? rec_r.duration : '0;
    res.found_ref      = hit_r ? rec_r.record_ref : '0;
    res.entry_count    = 8'(count_r);
  end

endmodule

// File: rtl/keyed_record_table_compacting_core.sv
// Top level of the keyed record table with compacting delete.
// Records sit in insertion order in one synchronous memory of DEPTH entries; one request
// is handled at a time. A search reads one entry per cycle through the single read port
// and compares each entry in the cycle after its read; it ends at the first hit or after
// every entry, then come the result state and the return to idle. A delete adds a shift
// that moves each later entry down one place. Full and empty cases skip the search. The
// result goes into an output register, so a new request is taken while the last
// result still waits. The memory needs no clearing after reset: only entries below
// the record count are ever read.
`include "keyed_record_table_compacting_core_assert.svh"

module keyed_record_table_compacting_core
  import kct_pkg::*;
#(
  parameter int DEPTH = KCT_DEPTH
) (
  input logic clk,
  input logic rst_n,
  kct_in_if.sink    in_ch,
  kct_out_if.source out_ch
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         in_item;
  res_t          res;
  logic          res_valid;
  logic          res_ready;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  rec_t          mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  rec_t          mem_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  assign in_item = '{kind: kind_t'(in_ch.kind), key: in_ch.key,
                     duration: in_ch.duration, record_ref: in_ch.record_ref};

  kct_ctrl #(
    .DEPTH(DEPTH),
    .IW   (IW),
    .CW   (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  kct_mem #(
    .DEPTH(DEPTH),
    .IW   (IW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.found_index    = out_res_r.found_index;
  assign out_ch.found_key      = out_res_r.found_key;
  assign out_ch.found_duration = out_res_r.found_duration;
  assign out_ch.found_ref      = out_res_r.found_ref;
  assign out_ch.entry_count    = out_res_r.entry_count;

  // The sequencer is busy in the cycle after a request transfer
  `KCT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)

  // A full report only comes with a full table
  `KCT_ASSERT_NOW(a_full_count, clk, rst_n, out_ch.valid && out_ch.status == ST_FULL,
                  out_ch.entry_count == 8'(DEPTH))

  // Missing and empty reports carry a zero index, key and reference
  `KCT_ASSERT_NOW(a_miss_zero, clk, rst_n,
                  out_ch.valid && (out_ch.status == ST_MISSING || out_ch.status == ST_EMPTY),
                  out_ch.found_index == '0 && out_ch.found_key == '0 && out_ch.found_ref == '0)

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the keyed record table with compacting delete.
module testbench;
  import kct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE_TIME  = 300;
  localparam int PRINT_LIMIT  = 100;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;

  kct_in_if  in_ch ();
  kct_out_if out_ch ();

  keyed_record_table_compacting_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the table, kept in insertion order
  logic signed [31:0] tbl_key [KCT_DEPTH];
  logic [23:0]        tbl_dur [KCT_DEPTH];
  logic [31:0]        tbl_ref [KCT_DEPTH];
  int                 tbl_count;

  res_t pending_results [$];

  int src_idle_max;
  int snk_idle_max;
  int results_checked;
  int mismatch_count;
  int idle_cycles;
  int kind_sent [4];
  int status_seen [5];

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Copy out one stored record as a result
  function automatic res_t describe_entry(status_t st, int pos);
    res_t r;
    r = '0;
    r.status         = st;
    r.found_index    = pos[6:0];
    r.found_key      = tbl_key[pos];
    r.found_duration = tbl_dur[pos];
    r.found_ref      = tbl_ref[pos];
    return r;
  endfunction

  // Apply one request to the shadow table and return the result it must give
  function automatic res_t table_response(item_t it);
    res_t r;
    int   pos;
    int   i;
    bit   hit;
    r   = '0;
    pos = 0;
    hit = 1'b0;
    for (i = 0; i < tbl_count; i++) begin
      if (!hit && tbl_key[i] === it.key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    if (it.kind == KIND_INSERT) begin
      if (tbl_count >= KCT_DEPTH) begin
        r.status = ST_FULL;
      end else if (hit) begin
        r = describe_entry(ST_DUP, pos);
      end else begin
        pos          = tbl_count;
        tbl_key[pos] = it.key;
        tbl_dur[pos] = it.duration;
        tbl_ref[pos] = it.record_ref;
        tbl_count++;
        r = describe_entry(ST_OK, pos);
      end
    end else if (tbl_count == 0) begin
      r.status = ST_EMPTY;
    end else if (!hit) begin
      r.status = ST_MISSING;
    end else begin
      case (it.kind)
        KIND_LOOKUP: begin
          r = describe_entry(ST_OK, pos);
        end
        KIND_UPDATE: begin
          tbl_dur[pos] = it.duration;
          tbl_ref[pos] = it.record_ref;
          r = describe_entry(ST_OK, pos);
        end
        default: begin
          // Report the removed record, then close the gap
          r = describe_entry(ST_OK, pos);
          for (i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_dur[i] = tbl_dur[i + 1];
            tbl_ref[i] = tbl_ref[i + 1];
          end
          tbl_count--;
        end
      endcase
    end
    r.entry_count = tbl_count[7:0];
    status_seen[r.status]++;
    return r;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at result %0d: %s is %h, expected %h",
               results_checked, field, got, want);
  endtask

  // Drive one request and record its expected result at the transfer
  task automatic send_request(kind_t kind, logic signed [31:0] key,
                              logic [23:0] dur, logic [31:0] rref);
    item_t it;
    int    gap;
    it.kind       = kind;
    it.key        = key;
    it.duration   = dur;
    it.record_ref = rref;
    gap = $urandom_range(src_idle_max, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.key        <= key;
    in_ch.duration   <= dur;
    in_ch.record_ref <= rref;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    kind_sent[kind]++;
    pending_results.push_back(table_response(it));
  endtask

  // Hold off the sender until every expected result has come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly keys held in the table, some near misses, extremes and fresh keys
  function automatic logic signed [31:0] pick_key();
    int r;
    logic signed [31:0] k;
    r = $urandom_range(99, 0);
    if (tbl_count > 0 && r < 65) begin
      k = tbl_key[$urandom_range(tbl_count - 1, 0)];
    end else if (tbl_count > 0 && r < 75) begin
      k = tbl_key[$urandom_range(tbl_count - 1, 0)] ^ (32'sd1 << $urandom_range(31, 0));
    end else if (r < 80) begin
      case ($urandom_range(3, 0))
        0:       k = KEY_MIN;
        1:       k = KEY_MAX;
        2:       k = '0;
        default: k = -32'sd1;
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  task automatic send_random_request(int w_ins, int w_lk, int w_up, int w_del);
    int          r;
    kind_t       k;
    logic [23:0] d;
    logic [31:0] rf;
    r = $urandom_range(w_ins + w_lk + w_up + w_del - 1, 0);
    if (r < w_ins)                   k = KIND_INSERT;
    else if (r < w_ins + w_lk)       k = KIND_LOOKUP;
    else if (r < w_ins + w_lk + w_up) k = KIND_UPDATE;
    else                             k = KIND_DELETE;
    d  = 24'($urandom);
    rf = $urandom;
    case ($urandom_range(9, 0))
      0: d = '0;
      1: d = '1;
      default: ;
    endcase
    case ($urandom_range(9, 0))
      0: rf = '0;
      1: rf = '1;
      default: ;
    endcase
    send_request(k, pick_key(), d, rf);
  endtask

  // Lookup, update and delete on a table with no records
  task automatic test_empty_table();
    send_request(KIND_LOOKUP, KEY_MIN, 24'h0, 32'h0);
    send_request(KIND_UPDATE, KEY_MAX, 24'hff_ffff, 32'hffff_ffff);
    send_request(KIND_DELETE, 32'sd0, 24'h0, 32'h0);
    wait_for_results();
  endtask

  // Inserts at the field extremes, then duplicate keys
  task automatic test_insert_duplicate();
    send_request(KIND_INSERT, KEY_MIN, 24'h0, 32'h0);
    send_request(KIND_INSERT, KEY_MAX, 24'hff_ffff, 32'hffff_ffff);
    send_request(KIND_INSERT, 32'sd0, 24'h5a_5a5a, 32'ha5a5_a5a5);
    send_request(KIND_INSERT, -32'sd1, 24'h12_3456, 32'hdead_beef);
    send_request(KIND_INSERT, KEY_MAX, 24'h00_0001, 32'h0000_0001);
    send_request(KIND_INSERT, KEY_MIN, 24'hff_ffff, 32'hffff_ffff);
  endtask

  // Hits at both ends, misses, and an update read back
  task automatic test_lookup_update();
    send_request(KIND_LOOKUP, KEY_MIN, 24'h0, 32'h0);
    send_request(KIND_LOOKUP, -32'sd1, 24'h0, 32'h0);
    send_request(KIND_LOOKUP, 32'sd1, 24'h0, 32'h0);
    send_request(KIND_UPDATE, KEY_MIN, 24'hff_ffff, 32'hffff_ffff);
    send_request(KIND_UPDATE, 32'sh1234_5678, 24'h0, 32'h0);
    send_request(KIND_LOOKUP, KEY_MIN, 24'h0, 32'h0);
  endtask

  // Delete from the middle, the end and the front down to empty
  task automatic test_delete_positions();
    send_request(KIND_DELETE, 32'sd0, 24'h0, 32'h0);
    send_request(KIND_DELETE, 32'sd5, 24'h0, 32'h0);
    send_request(KIND_DELETE, -32'sd1, 24'h0, 32'h0);
    send_request(KIND_DELETE, KEY_MIN, 24'h0, 32'h0);
    send_request(KIND_DELETE, KEY_MAX, 24'h0, 32'h0);
    send_request(KIND_DELETE, KEY_MAX, 24'h0, 32'h0);
    send_request(KIND_INSERT, KEY_MAX, 24'h00_abcd, 32'h0bad_cafe);
    send_request(KIND_LOOKUP, KEY_MAX, 24'h0, 32'h0);
    wait_for_results();
  endtask

  // Fill every slot, then work the full table at its deepest positions
  task automatic test_full_table();
    while (tbl_count < KCT_DEPTH) begin
      if ($urandom_range(7, 0) == 0)
        send_request(KIND_INSERT, tbl_key[$urandom_range(tbl_count - 1, 0)],
                     24'($urandom), $urandom);
      else
        send_request(KIND_INSERT, $urandom, 24'($urandom), $urandom);
    end
    send_request(KIND_INSERT, $urandom, 24'($urandom), $urandom);
    send_request(KIND_INSERT, tbl_key[0], 24'h0, 32'h0);
    send_request(KIND_LOOKUP, tbl_key[KCT_DEPTH - 1], 24'h0, 32'h0);
    send_request(KIND_UPDATE, tbl_key[KCT_DEPTH - 1], 24'hff_ffff, 32'h0);
    send_request(KIND_DELETE, tbl_key[0], 24'h0, 32'h0);
    send_request(KIND_LOOKUP, tbl_key[KCT_DEPTH - 2], 24'h0, 32'h0);
    send_request(KIND_INSERT, $urandom, 24'($urandom), $urandom);
    send_request(KIND_INSERT, $urandom, 24'($urandom), $urandom);
    wait_for_results();
  endtask

  // Random traffic with a given operation mix and idle setting
  task automatic test_random_traffic(int n, int w_ins, int w_lk, int w_up, int w_del,
                                     int src_max, int snk_max);
    src_idle_max = src_max;
    snk_idle_max = snk_max;
    repeat (n) send_random_request(w_ins, w_lk, w_up, w_del);
    wait_for_results();
  endtask

  // Result sink: random stall before each transfer
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(snk_idle_max, 0);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", 32'(out_ch.status), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        if (out_ch.found_index !== want.found_index)
          report_mismatch("found_index", 32'(out_ch.found_index), 32'(want.found_index));
        if (out_ch.found_key !== want.found_key)
          report_mismatch("found_key", out_ch.found_key, want.found_key);
        if (out_ch.found_duration !== want.found_duration)
          report_mismatch("found_duration", 32'(out_ch.found_duration),
                          32'(want.found_duration));
        if (out_ch.found_ref !== want.found_ref)
          report_mismatch("found_ref", out_ch.found_ref, want.found_ref);
        if (out_ch.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(out_ch.entry_count), 32'(want.entry_count));
      end
      results_checked++;
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid === 1'b1 && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_INSERT;
    in_ch.key        <= '0;
    in_ch.duration   <= '0;
    in_ch.record_ref <= '0;
    tbl_count       = 0;
    results_checked = 0;
    mismatch_count  = 0;
    idle_cycles     = 0;
    src_idle_max    = 18;
    snk_idle_max    = 18;
    kind_sent       = '{default: 0};
    status_seen     = '{default: 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_insert_duplicate();
    test_lookup_update();
    test_delete_positions();
    test_full_table();
    test_random_traffic(400, 10, 20, 20, 50, 18, 0);
    test_random_traffic(300, 25, 25, 25, 25, 0, 0);
    test_random_traffic(400, 60, 15, 15, 10, 18, 18);
    test_random_traffic(400, 25, 25, 25, 25, 0, 18);
    test_random_traffic(200, 5, 15, 15, 65, 6, 6);

    wait_for_results();
    repeat (SETTLE_TIME) @(posedge clk);

    $display("covered %0d inserts, %0d lookups, %0d updates, %0d deletes; %0d results checked",
             kind_sent[KIND_INSERT], kind_sent[KIND_LOOKUP], kind_sent[KIND_UPDATE],
             kind_sent[KIND_DELETE], results_checked);
    $display("outcomes: ok %0d, full %0d, duplicate %0d, not found %0d, empty %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
             status_seen[ST_MISSING], status_seen[ST_EMPTY], mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/kct_pkg.sv
rtl/kct_if.sv
rtl/kct_mem.sv
rtl/kct_ctrl.sv
rtl/keyed_record_table_compacting_core.sv
verif/testbench.sv
